/* rtl/gocd_pkg.sv */
// Package for the grid obstacle cross dilation block.
// Holds sizes, register codes and the structs shared by the front, queue and back.
// Depends on nothing.
`default_nettype none

package gocd_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int REACH     = 2;

	localparam int WW      = $clog2(MAX_WIDTH + 1);
	localparam int LAG_MAX = REACH * (MAX_WIDTH + 1);
	localparam int LW      = $clog2(LAG_MAX + 1);
	localparam int VAW     = $clog2(LAG_MAX + 1);
	localparam int MAW     = $clog2(2 * LAG_MAX + 1);
	localparam int NB      = 4 * REACH;
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);

	localparam int CFG_IW = 1;
	localparam int CFG_DW = WW;

	localparam int NB_LEFT  = 0;
	localparam int NB_UP    = 1;
	localparam int NB_RIGHT = 2;
	localparam int NB_DOWN  = 3;

	typedef enum logic [CFG_IW-1:0] {
		REG_MATCH_VALUE = CFG_IW'(0),
		REG_MAP_WIDTH   = CFG_IW'(1)
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]    match_value;
		logic [WW-1:0] width;
	} cfg_t;

	typedef struct packed {
		logic          wr;
		logic          emit;
		logic          mbit;
		logic [7:0]    cell_val;
		logic [VAW-1:0] vwr;
		logic [VAW-1:0] vrd;
		logic [MAW-1:0] hwr;
		logic [MAW-1:0] qh;
		logic [WW-1:0] row;
		logic [WW-1:0] col;
		logic          last;
		logic [NB-1:0] mask;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

/* rtl/gocd_front.sv */
// Front end: input and configuration handshakes, counters and command build.
// Accepted words make memory write and/or emit commands; idle drains make none.
// Depends on gocd_pkg.
`default_nettype none

module gocd_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // cell_in
	input  wire logic                          s_tuser,  // drain
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gocd_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [gocd_pkg::CFG_DW-1:0]   cfg_data,
	input  wire gocd_pkg::qstat_t              qstat,
	output logic                               push,
	output gocd_pkg::cmd_t                     cmd,
	output gocd_pkg::cfg_t                     cfg
);

	localparam int WW  = gocd_pkg::WW;
	localparam int LW  = gocd_pkg::LW;
	localparam int VAW = gocd_pkg::VAW;
	localparam int MAW = gocd_pkg::MAW;

	logic [7:0]     match_q;
	logic [WW-1:0]  width_q;
	logic [LW-1:0]  lag_q;
	logic [LW-1:0]  pend_q;
	logic [VAW-1:0] vrd_q;
	logic [MAW-1:0] hwr_q;
	logic [WW-1:0]  row_q;
	logic [WW-1:0]  col_q;

	logic           acc;
	logic           emit;
	logic [WW-1:0]  wsel;

	assign cfg_ready = 1'b1;
	assign s_tready  = !qstat.full && !cfg_valid;
	assign acc       = s_tvalid && s_tready;
	assign cfg.match_value = match_q;
	assign cfg.width       = width_q;

	always_comb begin
		if (cfg_data == '0) begin
			wsel = WW'(1);
		end else if (cfg_data > WW'(gocd_pkg::MAX_WIDTH)) begin
			wsel = WW'(gocd_pkg::MAX_WIDTH);
		end else begin
			wsel = cfg_data;
		end
	end

	always_comb begin
		emit          = s_tuser ? (pend_q != '0) : (pend_q >= lag_q);
		push          = acc && (!s_tuser || emit);
		cmd.wr        = !s_tuser;
		cmd.emit      = emit;
		cmd.mbit      = (s_tdata == match_q);
		cmd.cell_val  = s_tdata;
		cmd.vwr       = vrd_q + VAW'(pend_q);
		cmd.vrd       = vrd_q;
		cmd.hwr       = hwr_q;
		cmd.qh        = hwr_q - MAW'(pend_q);
		cmd.row       = row_q;
		cmd.col       = col_q;
		cmd.last      = (row_q == width_q - WW'(1)) && (col_q == width_q - WW'(1));
		for (int d = 1; d <= gocd_pkg::REACH; d++) begin
			cmd.mask[4*(d-1) + gocd_pkg::NB_LEFT] = (col_q >= WW'(d));
			cmd.mask[4*(d-1) + gocd_pkg::NB_UP]   = (row_q >= WW'(d));
			cmd.mask[4*(d-1) + gocd_pkg::NB_RIGHT] =
				(({1'b0, col_q} + (WW+1)'(d)) < {1'b0, width_q}) && (LW'(d) < pend_q);
			cmd.mask[4*(d-1) + gocd_pkg::NB_DOWN] =
				(({1'b0, row_q} + (WW+1)'(d)) < {1'b0, width_q}) &&
				((LW'(d) * LW'(width_q)) < pend_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			width_q <= WW'(gocd_pkg::MAX_WIDTH);
			lag_q   <= LW'(gocd_pkg::LAG_MAX);
			pend_q  <= '0;
			vrd_q   <= '0;
			hwr_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gocd_pkg::REG_MATCH_VALUE: begin
					match_q <= cfg_data[7:0];
				end
				gocd_pkg::REG_MAP_WIDTH: begin
					width_q <= wsel;
					lag_q   <= LW'(gocd_pkg::REACH) * (LW'(wsel) + LW'(1));
					pend_q  <= '0;
					vrd_q   <= '0;
					hwr_q   <= '0;
					row_q   <= '0;
					col_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (push) begin
			pend_q <= pend_q - LW'(emit) + LW'(!s_tuser);
			if (!s_tuser) begin
				hwr_q <= hwr_q + MAW'(1);
			end
			if (emit) begin
				vrd_q <= vrd_q + VAW'(1);
				if (col_q == width_q - WW'(1)) begin
					col_q <= '0;
					row_q <= (row_q == width_q - WW'(1)) ? '0 : row_q + WW'(1);
				end else begin
					col_q <= col_q + WW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/gocd_queue.sv */
// Short command queue between the front end and the back end.
// A register array with a fill count; the head word is always visible.
// Depends on gocd_pkg.
`default_nettype none

module gocd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire gocd_pkg::cmd_t  din,
	input  wire logic            pop,
	output gocd_pkg::cmd_t       dout,
	output gocd_pkg::qstat_t     qstat
);

	localparam int QAW = gocd_pkg::QAW;

	gocd_pkg::cmd_t slot_q [gocd_pkg::QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign dout        = slot_q[rd_ptr_q];
	assign qstat.full  = (count_q == (QAW+1)'(gocd_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/gocd_back.sv */
// Back end: value delay line, match history copies and the output register.
// Executes queued commands in order: writes, neighbour reads, then the result word.
// Depends on gocd_pkg.
`default_nettype none

module gocd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire gocd_pkg::cfg_t  cfg,
	input  wire gocd_pkg::cmd_t  cmd,
	input  wire logic            cmd_valid,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [23:0]          m_tdata,  // cell_out, out_row, out_col
	output logic                 m_tlast   // last_cell
);

	localparam int WW  = gocd_pkg::WW;
	localparam int VAW = gocd_pkg::VAW;
	localparam int MAW = gocd_pkg::MAW;
	localparam int NB  = gocd_pkg::NB;

	logic [7:0]     val_mem [2**VAW];
	logic [MAW-1:0] raddr   [NB+1];
	logic           mbit_s1 [NB+1];
	logic [7:0]     val_s1;
	logic           valid_s1;
	logic           emit_s1;
	logic [WW-1:0]  row_s1;
	logic [WW-1:0]  col_s1;
	logic           last_s1;
	logic [NB-1:0]  mask_s1;
	logic           move_s1;
	logic           hit;

	logic           out_valid_q;
	logic [7:0]     cell_q;
	logic [7:0]     row_q;
	logic [7:0]     col_q;
	logic           last_q;

	assign move_s1  = valid_s1 && (!emit_s1 || !out_valid_q || m_tready);
	assign pop      = cmd_valid && (!valid_s1 || move_s1);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {col_q, row_q, cell_q};
	assign m_tlast  = last_q;

	always_comb begin
		raddr[NB] = cmd.qh;
		for (int d = 1; d <= gocd_pkg::REACH; d++) begin
			raddr[4*(d-1) + gocd_pkg::NB_LEFT]  = cmd.qh - MAW'(d);
			raddr[4*(d-1) + gocd_pkg::NB_RIGHT] = cmd.qh + MAW'(d);
			raddr[4*(d-1) + gocd_pkg::NB_UP]    = cmd.qh - MAW'(d) * MAW'(cfg.width);
			raddr[4*(d-1) + gocd_pkg::NB_DOWN]  = cmd.qh + MAW'(d) * MAW'(cfg.width);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.wr) begin
			val_mem[cmd.vwr] <= cmd.cell_val;
		end
		if (pop) begin
			val_s1 <= val_mem[cmd.vrd];
		end
	end

	for (genvar k = 0; k <= NB; k++) begin : g_hist
		logic hist_mem [2**MAW];

		always_ff @(posedge clk) begin
			if (pop && cmd.wr) begin
				hist_mem[cmd.hwr] <= cmd.mbit;
			end
			if (pop) begin
				mbit_s1[k] <= hist_mem[raddr[k]];
			end
		end
	end

	always_comb begin
		hit = mbit_s1[NB];
		for (int k = 0; k < NB; k++) begin
			hit = hit | (mask_s1[k] & mbit_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_s1  <= cmd.row;
			col_s1  <= cmd.col;
			last_s1 <= cmd.last;
			mask_s1 <= cmd.mask;
		end
		if (move_s1 && emit_s1) begin
			cell_q <= hit ? cfg.match_value : val_s1;
			row_q  <= row_s1[7:0];
			col_q  <= col_s1[7:0];
			last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			emit_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
				emit_s1  <= cmd.emit;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1 && emit_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/grid_obstacle_cross_dilation.sv */
// Top level of the grid obstacle cross dilation block.
// Instantiates gocd_front, gocd_queue and gocd_back; depends on gocd_pkg.
//
// Channel   Direction  Handshake            Content
// s_*       in         s_tvalid/s_tready    tdata: cell_in; tuser: drain
// m_*       out        m_tvalid/m_tready    tdata: cell_out, out_row, out_col; tlast: last_cell
// cfg_*     in         cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// One word is accepted per clock while s_tready is high. A word that pushes a result out
// passes the queue entry, the memory read stage and the output register before the result
// appears on m_tvalid, with 2*W+2 words held in the line for a width W.
// The asynchronous reset clears control state only; the stores are not cleared.
// A stalled output fills the four-entry command queue before s_tready falls; s_tready
// is also low while a configuration write is offered.
`default_nettype none

module grid_obstacle_cross_dilation (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,  // [7:0] cell_in
	input  wire logic                         s_tuser,  // [0] drain
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [23:0]                       m_tdata,  // cell_out, out_row, out_col
	output logic                              m_tlast,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [gocd_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [gocd_pkg::CFG_DW-1:0]  cfg_data
);

	gocd_pkg::cmd_t   push_cmd;
	gocd_pkg::cmd_t   head_cmd;
	gocd_pkg::cfg_t   cfg;
	gocd_pkg::qstat_t qstat;
	logic             push;
	logic             pop;

	gocd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.push      (push),
		.cmd       (push_cmd),
		.cfg       (cfg)
	);

	gocd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (head_cmd),
		.qstat  (qstat)
	);

	gocd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (head_cmd),
		.cmd_valid (!qstat.empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	a_last_on_diagonal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[15:8] == m_tdata[23:16])
		else $error("last cell not on the diagonal");

	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("command queue full and empty at once");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("command taken from an empty queue");

endmodule

`default_nettype wire

/* sim/gocd_inflation_checker.sv */
// Checker for the grid obstacle cross dilation block: watches the configuration,
// input and output channels, predicts every inflated cell and compares it field by field.
// Depends on gocd_pkg for sizes and register codes.
`timescale 1ns / 1ps

module gocd_inflation_checker
	import gocd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [7:0]        s_tdata,
	input  wire logic              s_tuser,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [23:0]       m_tdata,
	input  wire logic              m_tlast,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	output int                     fail_count,
	output int                     results_due,
	output int                     cells_held,
	output int                     results_seen
);

	localparam int unsigned LINE_SZ = LAG_MAX;
	localparam int unsigned HIST_SZ = 2 * LAG_MAX;

	typedef struct packed {
		logic [7:0] cell_val;
		logic [7:0] row;
		logic [7:0] col;
		logic       last;
	} grid_cell_t;

	logic [7:0]    value_line [LINE_SZ];
	bit            match_bits [HIST_SZ];
	int unsigned   rd_ptr, hist_wr, held, out_row, out_col;
	logic [7:0]    obstacle;
	logic [WW-1:0] side_reg;
	grid_cell_t    inflated_due [$];

	function automatic int unsigned side_in_use();
		if (side_reg == '0)
			return 1;
		if (side_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return side_reg;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic restart_line();
		foreach (value_line[i])
			value_line[i] = '0;
		foreach (match_bits[i])
			match_bits[i] = 1'b0;
		rd_ptr = 0;
		hist_wr = 0;
		held = 0;
		out_row = 0;
		out_col = 0;
	endtask

	task automatic emit_inflated(input int unsigned w);
		int unsigned qh, r, c, d, dw;
		bit          hit;
		grid_cell_t  res;
		qh = (hist_wr + HIST_SZ - held) % HIST_SZ;
		r = out_row;
		c = out_col;
		hit = match_bits[qh];
		for (d = 1; d <= REACH; d++) begin
			dw = d * w;
			if (c >= d)
				hit |= match_bits[(qh + HIST_SZ - d) % HIST_SZ];
			if (r >= d)
				hit |= match_bits[(qh + HIST_SZ - dw) % HIST_SZ];
			if (c + d < w && d < held)
				hit |= match_bits[(qh + d) % HIST_SZ];
			if (r + d < w && dw < held)
				hit |= match_bits[(qh + dw) % HIST_SZ];
		end
		res.cell_val = hit ? obstacle : value_line[rd_ptr];
		res.row = r[7:0];
		res.col = c[7:0];
		res.last = (r + 1 == w) && (c + 1 == w);
		inflated_due.push_back(res);
		rd_ptr = (rd_ptr + 1) % LINE_SZ;
		held--;
		if (c + 1 >= w) begin
			out_col = 0;
			out_row = (r + 1 >= w) ? 0 : r + 1;
		end else begin
			out_col = c + 1;
		end
	endtask

	task automatic take_word(input logic [7:0] cell_val, input logic drain);
		int unsigned w;
		w = side_in_use();
		if (drain) begin
			if (held != 0)
				emit_inflated(w);
		end else begin
			if (held >= REACH * (w + 1))
				emit_inflated(w);
			value_line[(rd_ptr + held) % LINE_SZ] = cell_val;
			match_bits[hist_wr] = (cell_val == obstacle);
			hist_wr = (hist_wr + 1) % HIST_SZ;
			held++;
		end
	endtask

	task automatic check_result();
		grid_cell_t want;
		grid_cell_t got;
		got = '{cell_val: m_tdata[7:0], row: m_tdata[15:8], col: m_tdata[23:16],
			last: m_tlast};
		results_seen++;
		if (inflated_due.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with none due", results_seen));
		end else begin
			want = inflated_due.pop_front();
			if (got.cell_val !== want.cell_val)
				report_mismatch($sformatf("result %0d cell_out expected %0h got %0h",
					results_seen, want.cell_val, got.cell_val));
			if (got.row !== want.row)
				report_mismatch($sformatf("result %0d out_row expected %0d got %0d",
					results_seen, want.row, got.row));
			if (got.col !== want.col)
				report_mismatch($sformatf("result %0d out_col expected %0d got %0d",
					results_seen, want.col, got.col));
			if (got.last !== want.last)
				report_mismatch($sformatf("result %0d last_cell expected %0b got %0b",
					results_seen, want.last, got.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle = '0;
			side_reg = WW'(MAX_WIDTH);
			restart_line();
			inflated_due.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_MATCH_VALUE: obstacle = cfg_data[7:0];
					REG_MAP_WIDTH: begin
						side_reg = cfg_data;
						restart_line();
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_word(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				check_result();
		end
		results_due = inflated_due.size();
		cells_held = held;
	end

endmodule

/* sim/tb_grid_obstacle_cross_dilation.sv */
// Testbench top for the grid obstacle cross dilation block: makes clock, reset,
// configuration writes and cell words, throttles the output and gives the verdict.
// Depends on gocd_pkg, grid_obstacle_cross_dilation and gocd_inflation_checker.
`timescale 1ns / 1ps

module tb_grid_obstacle_cross_dilation;
	import gocd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic [7:0]        s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tready = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	wire logic         s_tready;
	wire logic         m_tvalid;
	wire logic [23:0]  m_tdata;
	wire logic         m_tlast;
	wire logic         cfg_ready;

	int         fail_count, results_due, cells_held, results_seen;
	int         cycles = 0;
	int         words_sent = 0;
	int         phase_count = 0;
	bit         sender_steady = 1'b1;
	bit         hold_request = 1'b0;
	logic [7:0] obstacle = '0;

	always #4 clk = ~clk;

	grid_obstacle_cross_dilation DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gocd_inflation_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.results_due  (results_due),
		.cells_held   (cells_held),
		.results_seen (results_seen)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still due", cycles, results_due);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [7:0] grid_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return obstacle;
		if (r < 30)
			return 8'h00;
		if (r < 35)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// The readiness is sampled at the falling edge, where it is settled for the next rising one.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input logic [7:0] cell_val, input logic drain);
		bit ok;
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= cell_val;
		s_tuser <= drain;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		words_sent++;
		gap = sender_steady ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			s_tuser <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (results_due != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic flush_line(input int extra);
		int n;
		s_tvalid <= 1'b0;
		@(negedge clk);
		n = cells_held;
		@(posedge clk);
		repeat (n + extra) send_word(8'($urandom), 1'b1);
	endtask

	task automatic run_phase(input logic [CFG_DW-1:0] width_val, input logic [7:0] match_val,
			input int n_cells, input bit steady, input bit mid_match, input bit squeeze,
			input int extra_drains, input bit flush);
		settle();
		obstacle = match_val;
		write_reg(REG_MATCH_VALUE, {1'($urandom), match_val});
		write_reg(REG_MAP_WIDTH, width_val);
		sender_steady = steady;
		if (squeeze)
			hold_request = 1'b1;
		for (int i = 0; i < n_cells; i++) begin
			if (mid_match && i == n_cells / 2) begin
				settle();
				obstacle = 8'($urandom);
				write_reg(REG_MATCH_VALUE, {1'b0, obstacle});
			end
			if ($urandom_range(0, 19) == 0)
				send_word(8'($urandom), 1'b1);
			send_word(grid_value(), 1'b0);
		end
		if (flush)
			flush_line(extra_drains);
		else
			repeat (extra_drains) send_word(8'($urandom), 1'b1);
		phase_count++;
	endtask

	initial begin : receiver
		int  gap;
		int  mode_left;
		bit  fast;
		mode_left = 0;
		fast = 1'b0;
		forever begin
			if (mode_left == 0) begin
				fast = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(50, 200);
			end
			mode_left--;
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
				gap = fast ? 0 : gap_len();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: a width of zero taken as one, then a full three by three grid.
		obstacle = 8'hFF;
		write_reg(REG_MATCH_VALUE, 9'h1FF);
		write_reg(REG_MAP_WIDTH, '0);
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		flush_line(0);
		settle();
		write_reg(REG_MAP_WIDTH, 9'd3);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h11, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h7E, 1'b0);
		send_word(8'hFF, 1'b0);
		flush_line(1);
		phase_count++;

		run_phase(9'd2, 8'h00, 40, 1'b0, 1'b0, 1'b0, 2, 1'b1);
		run_phase(9'd7, 8'($urandom), 60, 1'b0, 1'b1, 1'b0, 1, 1'b1);
		run_phase(9'd4, 8'($urandom), 60, 1'b1, 1'b0, 1'b1, 1, 1'b1);
		run_phase(9'd511, 8'hFF, 70, 1'b0, 1'b0, 1'b0, 6, 1'b0);
		run_phase(9'd1, 8'($urandom), 30, 1'b0, 1'b0, 1'b0, 1, 1'b1);
		run_phase(9'd16, 8'($urandom), 40, 1'b1, 1'b0, 1'b0, 2, 1'b1);
		run_phase(9'd256, 8'($urandom), 20, 1'b0, 1'b0, 1'b0, 0, 1'b1);
		settle();

		$display("Covered %0d phases with widths from 1 to 256 and %0d input words,",
			phase_count, words_sent);
		$display("including a long output stall and a mid-stream match change; %0d results compared.",
			results_seen);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
